>>> hdl/vn_pkg.sv
package vn_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } vn_in_t;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic               zero_length;
    } vn_out_t;

    // per-item data that rides along the root pipeline
    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } vn_side_t;

    // left shift that brings the largest magnitude to at least 2^30
    function automatic logic [4:0] norm_shift(input logic [31:0] m);
        logic [4:0] msb;
        logic [4:0] k;
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
            begin
                msb = 5'(i);
            end
        end
        if (msb >= 5'd30)
        begin
            k = 5'd0;
        end
        else
        begin
            k = 5'd30 - msb;
        end
        return k;
    endfunction

endpackage

>>> hdl/vn_prep.sv
module vn_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  vn_pkg::vn_in_t   in_data,
    output logic             out_valid,
    output logic [63:0]      sum_sq,
    output vn_pkg::vn_side_t side
);

    logic [2:0]       p1_valid_reg;
    logic [2:0]       p1_valid_next;
    logic [2:0][31:0] p1_mag_reg;
    logic [2:0][31:0] p1_mag_next;
    logic [2:0]       p1_neg_reg;
    logic [2:0]       p1_neg_next;
    logic [31:0]      p1_max_reg;
    logic [31:0]      p1_max_next;
    logic [2:0][31:0] p2_mag_reg;
    logic [2:0][31:0] p2_mag_next;
    logic [2:0]       p2_neg_reg;
    logic             p2_zero_reg;
    logic             p2_zero_next;
    logic [2:0][63:0] p3_sq_reg;
    logic [2:0][63:0] p3_sq_next;
    vn_pkg::vn_side_t p3_side_reg;
    vn_pkg::vn_side_t p4_side_reg;
    logic [63:0]      p4_sum_reg;
    logic [63:0]      p4_sum_next;
    logic [4:0]       shift_amt;

    assign p1_valid_next = {p1_valid_reg[1:0], in_valid};

    // stage 1: sign and magnitude, largest magnitude
    always_comb
    begin
        logic [2:0][31:0] v;
        v[0] = in_data.in_x;
        v[1] = in_data.in_y;
        v[2] = in_data.in_z;
        p1_max_next = 32'd0;
        for (int i = 0; i < 3; i++)
        begin
            p1_neg_next[i] = v[i][31];
            p1_mag_next[i] = v[i][31] ? (32'd0 - v[i]) : v[i];
            if (p1_mag_next[i] > p1_max_next)
            begin
                p1_max_next = p1_mag_next[i];
            end
        end
    end

    // stage 2: common normalizing shift
    assign shift_amt    = vn_pkg::norm_shift(p1_max_reg);
    assign p2_zero_next = (p1_max_reg == 32'd0);
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p2_mag_next[i] = p1_mag_reg[i] << shift_amt;
        end
    end

    // stage 3: squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p3_sq_next[i] = 64'(p2_mag_reg[i]) * 64'(p2_mag_reg[i]);
        end
    end

    // stage 4: sum of squares, cannot overflow 64 bits
    assign p4_sum_next = p3_sq_reg[0] + p3_sq_reg[1] + p3_sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= '0;
            out_valid    <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= p1_valid_next;
            out_valid    <= p1_valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_mag_reg       <= p1_mag_next;
            p1_neg_reg       <= p1_neg_next;
            p1_max_reg       <= p1_max_next;
            p2_mag_reg       <= p2_mag_next;
            p2_neg_reg       <= p1_neg_reg;
            p2_zero_reg      <= p2_zero_next;
            p3_sq_reg        <= p3_sq_next;
            p3_side_reg.mag  <= p2_mag_reg;
            p3_side_reg.neg  <= p2_neg_reg;
            p3_side_reg.zero <= p2_zero_reg;
            p4_sum_reg       <= p4_sum_next;
            p4_side_reg      <= p3_side_reg;
        end
    end

    assign sum_sq = p4_sum_reg;
    assign side   = p4_side_reg;

endmodule

>>> hdl/vn_sqrt.sv
module vn_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      sum_sq,
    input  vn_pkg::vn_side_t in_side,
    output logic             out_valid,
    output logic [32:0]      root,
    output vn_pkg::vn_side_t out_side
);

    localparam int N = vn_pkg::SQRT_STEPS;

    logic             valid_reg [N+1];
    logic [63:0]      rem_reg   [N+1];
    logic [63:0]      root_reg  [N+1];
    vn_pkg::vn_side_t side_reg  [N+1];
    logic             rnd_valid_reg;
    logic [32:0]      rnd_root_reg;
    logic [32:0]      rnd_root_next;
    vn_pkg::vn_side_t rnd_side_reg;

    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = sum_sq;
        root_reg[0]  = 64'd0;
        side_reg[0]  = in_side;
    end

    // one result bit per stage, shift-subtract square root
    for (genvar j = 0; j < N; j++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] root_next;

        assign trial = root_reg[j] + BIT;
        always_comb
        begin
            if (rem_reg[j] >= trial)
            begin
                rem_next  = rem_reg[j] - trial;
                root_next = (root_reg[j] >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_reg[j];
                root_next = root_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                root_reg[j+1] <= root_next;
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    // round to nearest
    assign rnd_root_next = root_reg[N][32:0] +
                           33'((rem_reg[N] > root_reg[N]) ? 1 : 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rnd_valid_reg <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_root_reg <= rnd_root_next;
            rnd_side_reg <= side_reg[N];
        end
    end

    assign out_valid = rnd_valid_reg;
    assign root      = rnd_root_reg;
    assign out_side  = rnd_side_reg;

endmodule

>>> hdl/vn_div.sv
module vn_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [32:0]      root,
    input  vn_pkg::vn_side_t in_side,
    output logic             out_valid,
    output vn_pkg::vn_out_t  out_data
);

    localparam int N = vn_pkg::DIV_STEPS;

    logic             valid_reg [N+1];
    logic [2:0][32:0] rem_reg   [N+1];
    logic [2:0][31:0] low_reg   [N+1];
    logic [2:0][31:0] quo_reg   [N+1];
    logic [32:0]      div_reg   [N+1];
    logic [2:0]       neg_reg   [N+1];
    logic             zero_reg  [N+1];
    logic [2:0][32:0] rem_next0;
    logic [2:0][31:0] low_next0;
    logic             out_valid_reg;
    vn_pkg::vn_out_t  out_data_reg;
    vn_pkg::vn_out_t  out_data_next;

    // dividend m * 2^30 + r/2; upper part is already below the divisor
    always_comb
    begin
        logic [61:0] dvd;
        for (int i = 0; i < 3; i++)
        begin
            dvd = {in_side.mag[i][31:0], 30'd0} + 62'(root >> 1);
            rem_next0[i] = 33'(dvd[61:32]);
            low_next0[i] = dvd[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next0;
            low_reg[0]  <= low_next0;
            quo_reg[0]  <= '0;
            div_reg[0]  <= root;
            neg_reg[0]  <= in_side.neg;
            zero_reg[0] <= in_side.zero;
        end
    end

    // one quotient bit per stage in each of the three lanes
    for (genvar j = 0; j < N; j++)
    begin : g_step
        logic [2:0][32:0] rem_next;
        logic [2:0][31:0] quo_next;

        always_comb
        begin
            logic [33:0] t;
            for (int i = 0; i < 3; i++)
            begin
                t = {rem_reg[j][i], low_reg[j][i][31 - j]};
                if (t >= 34'(div_reg[j]))
                begin
                    rem_next[i] = 33'(t - 34'(div_reg[j]));
                    quo_next[i] = {quo_reg[j][i][30:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = t[32:0];
                    quo_next[i] = {quo_reg[j][i][30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                low_reg[j+1]  <= low_reg[j];
                quo_reg[j+1]  <= quo_next;
                div_reg[j+1]  <= div_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                zero_reg[j+1] <= zero_reg[j];
            end
        end
    end

    // clamp to one, apply sign, force zero vector
    always_comb
    begin
        logic [2:0][31:0] res;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = (quo_reg[N][i] > vn_pkg::ONE_Q30) ? vn_pkg::ONE_Q30 : quo_reg[N][i];
            if (neg_reg[N][i])
            begin
                res[i] = 32'd0 - res[i];
            end
            if (zero_reg[N])
            begin
                res[i] = 32'd0;
            end
        end
        out_data_next.unit_x      = res[0];
        out_data_next.unit_y      = res[1];
        out_data_next.unit_z      = res[2];
        out_data_next.zero_length = zero_reg[N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/vector3_normalize.sv
// vector3_normalize: scales a 3-component vector to unit length
// input channel: in_valid / in_ready carry one request, in_data with
//   in_x, in_y, in_z in signed q16.16
// output channel: out_valid / out_ready carry one result, out_data with
//   unit_x, unit_y, unit_z in signed q2.30 and the zero_length flag
// pipeline: 71 register stages from in_data to out_data
//   magnitude, shift, square and sum stages
//   square root, one root bit per stage plus rounding
//   divider setup, one quotient bit per stage, output register
// throughput: one request per cycle unless out_ready stalls, fixed by the fully pipelined root
//   and divider stages; the block holds no state between requests
// reset clears only the valid bits, the pipeline comes up empty
// a stall on out_ready freezes every stage at once; in_ready falls with it,
//   and a new request is still taken in the cycle the result leaves
module vector3_normalize (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vn_pkg::vn_in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output vn_pkg::vn_out_t out_data
);

    logic             en;
    logic             prep_valid;
    logic [63:0]      prep_sum;
    vn_pkg::vn_side_t prep_side;
    logic             sqrt_valid;
    logic [32:0]      sqrt_root;
    vn_pkg::vn_side_t sqrt_side;

    // whole pipeline advances unless a result sits unclaimed
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    vn_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (prep_valid),
        .sum_sq    (prep_sum),
        .side      (prep_side)
    );

    vn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .sum_sq    (prep_sum),
        .in_side   (prep_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    vn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .root      (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> test/vector3_normalize_test.sv
`timescale 1ns / 100ps

module vector3_normalize_test;

    localparam int LATENCY     = 71;
    localparam int RANDOM_REQS = 600;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    vn_pkg::vn_in_t  in_data;
    logic            out_valid;
    logic            out_ready;
    vn_pkg::vn_out_t out_data;

    vn_pkg::vn_out_t expected_units[$];
    int              error_count;
    bit              sending_done;

    // directed rows: vector, whether the result is typed in, and that result
    typedef struct {
        vn_pkg::vn_in_t  vec;
        bit              fixed;
        vn_pkg::vn_out_t res;
    } vec_row_t;

    vector3_normalize dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // rounded integer square root of a 64-bit sum
    function automatic logic [63:0] round_sqrt(input logic [63:0] s);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = s;
        root = 64'd0;
        b    = 64'd1 << 62;
        while (b > rem)
        begin
            b = b >> 2;
        end
        while (b != 64'd0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        if (rem > root)
        begin
            root = root + 64'd1;
        end
        return root;
    endfunction

    function automatic vn_pkg::vn_out_t unit_vector(input vn_pkg::vn_in_t v);
        logic [2:0][31:0] raw;
        logic [63:0]      mag [3];
        logic             neg [3];
        logic [63:0]      peak;
        logic [63:0]      sum;
        logic [63:0]      len;
        logic [63:0]      q;
        logic [31:0]      comp [3];
        vn_pkg::vn_out_t  res;
        raw  = {v.in_x, v.in_y, v.in_z};
        peak = 64'd0;
        sum  = 64'd0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = raw[2 - i][31];
            mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, raw[2 - i]} : {32'd0, raw[2 - i]};
            if (mag[i] > peak)
            begin
                peak = mag[i];
            end
        end
        res = '0;
        if (peak == 64'd0)
        begin
            res.zero_length = 1'b1;
            return res;
        end
        // normalize so the largest magnitude has its top bit at 30 or 31
        while (peak < (64'd1 << 30))
        begin
            peak = peak << 1;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = mag[i] << 1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            sum = sum + mag[i] * mag[i];
        end
        len = round_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            if (q > (64'd1 << 30))
            begin
                q = 64'd1 << 30;
            end
            comp[i] = neg[i] ? 32'(-q) : q[31:0];
        end
        res.unit_x = comp[0];
        res.unit_y = comp[1];
        res.unit_z = comp[2];
        return res;
    endfunction

    function automatic logic [31:0] random_component();
        logic [31:0] c;
        case ($urandom_range(0, 5))
            0: c = $urandom_range(0, 15);
            1: c = -$urandom_range(0, 15);
            2: c = $urandom >> $urandom_range(0, 31);
            3: c = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            4: c = 32'd0;
            default: c = $urandom;
        endcase
        return c;
    endfunction

    // valid drops only while idling, so back-to-back requests keep it high
    task automatic send_vector(input vn_pkg::vn_in_t v, input int idle);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // expectation is queued at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_units.push_back(unit_vector(in_data));
        end
    end

    // directed table overrides the predictor where the row carries a result
    vn_pkg::vn_out_t typed_results[$];
    bit              typed_flags[$];

    always @(posedge clk)
    begin
        vn_pkg::vn_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_units.size() == 0)
            begin
                $error("unit_x: result with no request waiting, got %0d", out_data.unit_x);
                error_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (typed_flags.size() != 0)
                begin
                    if (typed_flags.pop_front())
                    begin
                        want = typed_results.pop_front();
                    end
                    else
                    begin
                        void'(typed_results.pop_front());
                    end
                end
                if (out_data.unit_x !== want.unit_x)
                begin
                    $error("unit_x: expected %0d, got %0d", want.unit_x, out_data.unit_x);
                    error_count++;
                end
                if (out_data.unit_y !== want.unit_y)
                begin
                    $error("unit_y: expected %0d, got %0d", want.unit_y, out_data.unit_y);
                    error_count++;
                end
                if (out_data.unit_z !== want.unit_z)
                begin
                    $error("unit_z: expected %0d, got %0d", want.unit_z, out_data.unit_z);
                    error_count++;
                end
                if (out_data.zero_length !== want.zero_length)
                begin
                    $error("zero_length: expected %0b, got %0b",
                           want.zero_length, out_data.zero_length);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls, redrawn per result; quiet stretches included
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold)
                begin
                    @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
            begin
                @(posedge clk);
            end
        end
    end

    localparam logic [31:0] ONE  = 32'h4000_0000;
    localparam logic [31:0] MONE = 32'hC000_0000;

    function automatic vn_pkg::vn_out_t unit_of(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] z, input logic zl);
        vn_pkg::vn_out_t r;
        r.unit_x      = x;
        r.unit_y      = y;
        r.unit_z      = z;
        r.zero_length = zl;
        return r;
    endfunction

    initial
    begin
        vec_row_t       table_rows[$];
        vn_pkg::vn_in_t v;
        error_count  = 0;
        sending_done = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;

        // zero vector, single axes large and small, diagonals, tiny and huge mixes
        table_rows = '{
            '{'{32'd0, 32'd0, 32'd0}, 1, unit_of(0, 0, 0, 1)},
            '{'{32'h8000_0000, 32'd0, 32'd0}, 1, unit_of(MONE, 0, 0, 0)},
            '{'{32'd0, 32'h7FFF_FFFF, 32'd0}, 1, unit_of(0, ONE, 0, 0)},
            '{'{32'd0, 32'd0, 32'd1}, 1, unit_of(0, 0, ONE, 0)},
            '{'{32'hFFFF_FFFF, 32'd0, 32'd0}, 1, unit_of(MONE, 0, 0, 0)},
            '{'{32'd0, 32'h8000_0000, 32'd0}, 1, unit_of(0, MONE, 0, 0)},
            '{'{32'd0, 32'd0, 32'h8000_0000}, 1, unit_of(0, 0, MONE, 0)},
            '{'{32'd0, 32'd0, 32'h0001_0000}, 1, unit_of(0, 0, ONE, 0)},
            '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, '0},
            '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, '0},
            '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'd1}, 0, '0},
            '{'{32'd1, 32'd1, 32'd1}, 0, '0},
            '{'{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}, 0, '0},
            '{'{32'h0003_0000, 32'h0004_0000, 32'd0}, 0, '0},
            '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F}, 0, '0},
            '{'{32'd1, 32'h7FFF_FFFF, 32'd2}, 0, '0}
        };

        repeat (7)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            typed_flags.push_back(table_rows[i].fixed);
            typed_results.push_back(table_rows[i].res);
            send_vector(table_rows[i].vec, $urandom_range(0, 5));
        end
        in_valid <= 1'b0;

        // pause with the pipe drained before the random stream
        @(posedge clk);
        while (expected_units.size() != 0)
        begin
            @(posedge clk);
        end

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            v.in_x = random_component();
            v.in_y = random_component();
            v.in_z = random_component();
            if ($urandom_range(0, 7) == 0)
            begin
                // single axis case
                case ($urandom_range(0, 2))
                    0: begin v.in_y = 0; v.in_z = 0; end
                    1: begin v.in_x = 0; v.in_z = 0; end
                    default: begin v.in_x = 0; v.in_y = 0; end
                endcase
            end
            if (n % 64 < 16)
            begin
                // back-to-back burst
                send_vector(v, 0);
            end
            else
            begin
                send_vector(v, $urandom_range(0, 5));
            end
        end
        in_valid <= 1'b0;
        sending_done = 1;
    end

    initial
    begin
        wait (sending_done);
        while (expected_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10)
        begin
            @(posedge clk);
        end
        if (error_count == 0)
        begin
            $display("vector3_normalize_test: clean");
        end
        else
        begin
            $display("vector3_normalize_test: errors");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("vector3_normalize_test: errors");
        $finish;
    end

endmodule

>>> vector3_normalize.f
hdl/vn_pkg.sv
hdl/vn_prep.sv
hdl/vn_sqrt.sv
hdl/vn_div.sv
hdl/vector3_normalize.sv
test/vector3_normalize_test.sv
